/* design/tcct_pkg.sv */
// shared types, codes and constants of the tcp client connection tracker
package tcct_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] LOCAL_SEQ_RESET = 32'd1000;
	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;

	localparam logic [1:0] ST_NONE        = 2'd0;
	localparam logic [1:0] ST_SYN_SENT    = 2'd1;
	localparam logic [1:0] ST_ESTABLISHED = 2'd2;

	localparam logic MODE_CONNECT = 1'b0;
	localparam logic MODE_SEGMENT = 1'b1;

	localparam logic [3:0] V_OK             = 4'd0;
	localparam logic [3:0] V_SHORT          = 4'd1;
	localparam logic [3:0] V_RESET          = 4'd2;
	localparam logic [3:0] V_NO_SYNACK      = 4'd3;
	localparam logic [3:0] V_FIN_SYNSENT    = 4'd4;
	localparam logic [3:0] V_SYNACK_PAYLOAD = 4'd5;
	localparam logic [3:0] V_BAD_ACK        = 4'd6;
	localparam logic [3:0] V_SYN_ESTAB      = 4'd7;
	localparam logic [3:0] V_OUT_OF_ORDER   = 4'd8;
	localparam logic [3:0] V_ILLEGAL_STATE  = 4'd9;
	localparam logic [3:0] V_BAD_OFFSET     = 4'd10;

	typedef struct packed {
		logic        mode;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic        flag_fin;
		logic        flag_syn;
		logic        flag_rst;
		logic        flag_ack;
		logic [3:0]  data_offset;
		logic [15:0] segment_length;
	} item_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic        send_valid;
		logic [31:0] send_seq;
		logic [31:0] send_ack_num;
		logic        send_syn;
		logic        send_ack_bit;
		logic        send_request;
		logic        deliver_payload;
		logic [15:0] pay_bytes;
		logic [1:0]  conn_state_out;
	} result_t;

	// classified beat handed from front to back
	typedef struct packed {
		logic        mode;
		logic [3:0]  pre_verdict;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic        flag_fin;
		logic        flag_syn;
		logic        flag_ack;
		logic [15:0] pay_len;
	} cls_t;

endpackage

/* design/tcct_fifo.sv */
// small synchronous queue with registered storage
module tcct_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = tcct_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/tcct_front.sv */
// front end: stateless length, offset and reset checks, payload length
module tcct_front (
	input  tcct_pkg::item_t item,
	output tcct_pkg::cls_t  cls
);

	logic [15:0] off_bytes;

	assign off_bytes = {10'd0, item.data_offset, 2'b00};

	always_comb begin
		cls.mode     = item.mode;
		cls.seg_seq  = item.seg_seq;
		cls.seg_ack  = item.seg_ack;
		cls.flag_fin = item.flag_fin;
		cls.flag_syn = item.flag_syn;
		cls.flag_ack = item.flag_ack;
		cls.pay_len  = item.segment_length - off_bytes;
		if (item.mode == tcct_pkg::MODE_CONNECT) begin
			cls.pre_verdict = tcct_pkg::V_OK;
		end else if (item.segment_length < tcct_pkg::MIN_HEADER_BYTES) begin
			cls.pre_verdict = tcct_pkg::V_SHORT;
		end else if (off_bytes > item.segment_length) begin
			cls.pre_verdict = tcct_pkg::V_BAD_OFFSET;
		end else if (item.flag_rst) begin
			cls.pre_verdict = tcct_pkg::V_RESET;
		end else begin
			cls.pre_verdict = tcct_pkg::V_OK;
		end
	end

endmodule

/* design/tcct_back.sv */
// back end: connection state, sequence tracking and response building
module tcct_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  tcct_pkg::cls_t    cls,
	output tcct_pkg::result_t res
);

	logic [1:0]  state_q;
	logic [31:0] local_seq_q;
	logic [31:0] remote_seq_q;

	logic [1:0]  state_d;
	logic [31:0] local_seq_d;
	logic [31:0] remote_seq_d;
	logic [31:0] virt_len;

	assign virt_len = {16'd0, cls.pay_len} + {31'd0, cls.flag_fin};

	always_comb begin
		state_d      = state_q;
		local_seq_d  = local_seq_q;
		remote_seq_d = remote_seq_q;
		res          = '0;
		res.verdict  = tcct_pkg::V_OK;
		if (cls.mode == tcct_pkg::MODE_CONNECT) begin
			state_d        = tcct_pkg::ST_SYN_SENT;
			res.send_valid = 1'b1;
			res.send_seq   = local_seq_q;
			res.send_syn   = 1'b1;
		end else if (cls.pre_verdict != tcct_pkg::V_OK) begin
			res.verdict = cls.pre_verdict;
		end else begin
			case (state_q)
				tcct_pkg::ST_SYN_SENT: begin
					if (!cls.flag_syn || !cls.flag_ack) begin
						res.verdict = tcct_pkg::V_NO_SYNACK;
					end else if (cls.flag_fin) begin
						res.verdict = tcct_pkg::V_FIN_SYNSENT;
					end else if (cls.pay_len != '0) begin
						res.verdict = tcct_pkg::V_SYNACK_PAYLOAD;
					end else if (cls.seg_ack != local_seq_q + 32'd1) begin
						res.verdict = tcct_pkg::V_BAD_ACK;
					end else begin
						local_seq_d         = cls.seg_ack;
						remote_seq_d        = cls.seg_seq + 32'd1;
						state_d             = tcct_pkg::ST_ESTABLISHED;
						res.send_valid      = 1'b1;
						res.send_seq        = cls.seg_ack;
						res.send_ack_num    = cls.seg_seq + 32'd1;
						res.send_ack_bit    = 1'b1;
						res.send_request    = 1'b1;
						res.deliver_payload = 1'b1;
					end
				end
				tcct_pkg::ST_ESTABLISHED: begin
					if (cls.flag_syn) begin
						res.verdict = tcct_pkg::V_SYN_ESTAB;
					end else if (cls.seg_seq != remote_seq_q) begin
						res.verdict = tcct_pkg::V_OUT_OF_ORDER;
					end else begin
						if (cls.flag_ack) begin
							local_seq_d = cls.seg_ack;
						end
						remote_seq_d = cls.seg_seq + virt_len;
						if (virt_len != '0) begin
							res.send_valid   = 1'b1;
							res.send_seq     = local_seq_d;
							res.send_ack_num = remote_seq_d;
							res.send_ack_bit = 1'b1;
						end
						res.deliver_payload = 1'b1;
						res.pay_bytes       = cls.pay_len;
					end
				end
				default: begin
					res.verdict = tcct_pkg::V_ILLEGAL_STATE;
				end
			endcase
		end
		res.conn_state_out = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcct_pkg::ST_NONE;
			local_seq_q  <= tcct_pkg::LOCAL_SEQ_RESET;
			remote_seq_q <= '0;
		end else if (go) begin
			state_q      <= state_d;
			local_seq_q  <= local_seq_d;
			remote_seq_q <= remote_seq_d;
		end
	end

endmodule

/* design/tcp_client_connection_tracker.sv */
// top level of the tcp client connection tracker
// usage
//  - input channel is a queue write port: a beat (connect command or parsed
//    segment header) is taken at a rising edge with push high and full low
//  - result channel is a queue read port: the oldest result sits on result
//    while empty is low and leaves at an edge with pop high
//  - every input beat gives exactly one result beat, in order
// structure
//  - front: stateless checks (short segment, bad offset, rst) and payload
//    length, written straight into a short classified-beat queue
//  - back: pops that queue whenever the result queue has room, applies the
//    connection state machine and sequence updates, pushes the result
// timing
//  - a beat reaches the result ports through the classified queue, then the result queue
//  - throughput one beat per cycle while the result queue has room, set by the combinational back end update
// reset and stall
//  - arst_n empties both queues and returns to no connection, local
//    sequence 1000, remote sequence 0
//  - while pop stays low the result queue fills, the back end halts and then
//    full rises once the classified queue is full too
module tcp_client_connection_tracker #(
	parameter int QUEUE_DEPTH = tcct_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tcct_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output tcct_pkg::result_t result
);

	localparam int CLS_W = $bits(tcct_pkg::cls_t);
	localparam int RES_W = $bits(tcct_pkg::result_t);

	tcct_pkg::cls_t    cls_in;
	tcct_pkg::cls_t    cls_out;
	tcct_pkg::result_t res_new;
	logic              mid_empty;
	logic              res_full;
	logic              back_go;

	// classify the incoming beat
	tcct_front u_front (
		.item (item),
		.cls  (cls_in)
	);

	// queue between front and back
	tcct_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_in),
		.full    (full),
		.rd_en   (back_go),
		.rd_data (cls_out),
		.empty   (mid_empty)
	);

	// back end runs only when it has a beat and somewhere to put the result
	assign back_go = !mid_empty && !res_full;

	tcct_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (back_go),
		.cls    (cls_out),
		.res    (res_new)
	);

	// result queue, parts the back end from the receiver
	tcct_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_go),
		.wr_data (res_new),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
